FILE: rtl/sdresp_pkg.sv
// Shared constants, types and helpers for the SPI-mode SD card word responder.
package sdresp_pkg;

  localparam int unsigned DISK_SECTORS     = 256;
  localparam int unsigned WORDS_PER_SECTOR = 128;

  localparam int unsigned SECTOR_W    = (DISK_SECTORS > 1) ? $clog2(DISK_SECTORS) : 1;
  localparam int unsigned WORD_W      = $clog2(WORDS_PER_SECTOR);
  localparam int unsigned STORE_WORDS = DISK_SECTORS * WORDS_PER_SECTOR;
  localparam int unsigned STORE_AW    = $clog2(STORE_WORDS);
  localparam int unsigned REPLY_DEPTH = 2 + WORDS_PER_SECTOR;
  localparam int unsigned LEN_W       = $clog2(REPLY_DEPTH + 1);
  localparam int unsigned IDX_W       = $clog2(REPLY_DEPTH + 2) + 1;
  localparam int unsigned CNT_W       = $clog2(WORDS_PER_SECTOR + 3);

  localparam logic [31:0] CMD_READ_BLOCK  = 32'd81;
  localparam logic [31:0] CMD_WRITE_BLOCK = 32'd88;
  localparam logic [31:0] TOKEN_START     = 32'd254;
  localparam logic [7:0]  IDLE_BYTE       = 8'hFF;
  localparam logic [7:0]  TOKEN_BYTE      = 8'd254;
  localparam logic [7:0]  RESP_OK         = 8'd0;
  localparam logic [7:0]  RESP_DATA_OK    = 8'd5;
  localparam logic [7:0]  NO_REPLY        = 8'd255;
  localparam int unsigned CMD_WORDS       = 6;

  typedef enum logic [3:0] {
    MODE_CMD  = 4'b0001,
    MODE_READ = 4'b0010,
    MODE_WAIT = 4'b0100,
    MODE_RECV = 4'b1000
  } mode_e;

  // Flat word address of one word of one sector.
  function automatic logic [STORE_AW-1:0] store_addr(input logic [SECTOR_W-1:0] sec,
                                                     input logic [WORD_W-1:0] word);
    logic [STORE_AW+SECTOR_W-1:0] prod;
    prod = (STORE_AW+SECTOR_W)'(sec) * (STORE_AW+SECTOR_W)'(WORDS_PER_SECTOR)
         + (STORE_AW+SECTOR_W)'(word);
    return prod[STORE_AW-1:0];
  endfunction

endpackage

FILE: rtl/spi_sd_card_word_responder.sv
// Top level of the SPI-mode SD card word responder with its sector store.
//
//  channel   | ports                                   | direction
//  ----------+-----------------------------------------+----------
//  request   | start, busy, operation_i, value_i       | in
//  reply     | result_valid_o, read_data_o             | out
//  config    | cfg_we_i, cfg_wdata_i (sector offset)   | in
//
// A port write transaction (operation_i low) is finished in the cycle it is
// accepted; busy stays low and a new transaction may follow in the next cycle.
// A port read transaction (operation_i high) holds busy for one cycle while the
// sector store's registered read port delivers the word; the reply strobe is
// high in the cycle after that. Reset is asynchronous and active low. It
// clears the control state and the per-sector valid bits; a sector that was
// never written reads as zeros, so no clearing pass over the store is needed.
// The receiver cannot stall replies.
module spi_sd_card_word_responder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        operation_i,
  input  logic [31:0] value_i,
  output logic        result_valid_o,
  output logic [31:0] read_data_o,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);

  // Sector store and one valid bit per sector.
  logic [31:0] store_mem [sdresp_pkg::STORE_WORDS];
  logic [sdresp_pkg::DISK_SECTORS-1:0] sect_vld_q, sect_vld_d;

  // Protocol state.
  sdresp_pkg::mode_e                 mode_q, mode_d;
  logic [sdresp_pkg::CNT_W-1:0]      cnt_q, cnt_d;
  logic [sdresp_pkg::IDX_W-1:0]      idx_q, idx_d;
  logic [sdresp_pkg::LEN_W-1:0]      len_q, len_d;
  logic                              ack_q, ack_d;      // first reply word is 5, else 0
  logic                              sec_ok_q, sec_ok_d;
  logic [sdresp_pkg::SECTOR_W-1:0]   sec_q, sec_d;
  logic [31:0]                       code_q, code_d;
  logic [31:0]                       arg_q, arg_d;
  logic [31:0]                       off_q;

  // Read path.
  logic                              pend_q;
  logic                              sel_mem_q, sel_mem_d;
  logic                              mem_ok_q, mem_ok_d;
  logic [7:0]                        cval_q, cval_d;
  logic [31:0]                       rdata_q;
  logic                              out_vld_q;
  logic [31:0]                       out_q;

  logic                              acc_wr, acc_rd;
  logic [sdresp_pkg::IDX_W-1:0]      idx_inc;
  logic [31:0]                       sec_full;
  logic                              mem_we;
  logic [sdresp_pkg::STORE_AW-1:0]   wr_addr, rd_addr;
  logic [sdresp_pkg::IDX_W-1:0]      word_pos;

  assign acc_wr = start && !busy && !operation_i;
  assign acc_rd = start && !busy && operation_i;
  assign busy   = pend_q;

  assign idx_inc  = (idx_q != {sdresp_pkg::IDX_W{1'b1}}) ? idx_q + 1'b1 : idx_q;
  assign sec_full = arg_q - off_q;

  // Sector data words sit at reply positions two and up; idx holds position plus one.
  assign word_pos = idx_q - sdresp_pkg::IDX_W'(3);
  assign rd_addr  = sdresp_pkg::store_addr(sec_q, word_pos[sdresp_pkg::WORD_W-1:0]);
  assign wr_addr  = sdresp_pkg::store_addr(sec_q, cnt_q[sdresp_pkg::WORD_W-1:0]);
  assign mem_we   = acc_wr && (mode_q == sdresp_pkg::MODE_RECV) && sec_ok_q &&
                    (cnt_q < sdresp_pkg::CNT_W'(sdresp_pkg::WORDS_PER_SECTOR));

  // Port write handling: command collection, read-out, token wait and sector receive.
  always_comb begin
    mode_d     = mode_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    len_d      = len_q;
    ack_d      = ack_q;
    sec_ok_d   = sec_ok_q;
    sec_d      = sec_q;
    code_d     = code_q;
    arg_d      = arg_q;
    sect_vld_d = sect_vld_q;
    if (acc_wr) begin
      idx_d = idx_inc;
      case (mode_q)
        sdresp_pkg::MODE_CMD: begin
          if ((value_i[7:0] != sdresp_pkg::IDLE_BYTE) || (cnt_q != '0)) begin
            cnt_d = cnt_q + 1'b1;
            case (cnt_q)
              sdresp_pkg::CNT_W'(0): code_d = value_i;
              sdresp_pkg::CNT_W'(1): arg_d  = value_i << 24;
              sdresp_pkg::CNT_W'(2): arg_d  = arg_q | (value_i << 16);
              sdresp_pkg::CNT_W'(3): arg_d  = arg_q | (value_i << 8);
              sdresp_pkg::CNT_W'(4): arg_d  = arg_q | value_i;
              default: begin
                // Sixth word is the checksum: decode now.
                cnt_d = '0;
                ack_d = 1'b0;
                len_d = sdresp_pkg::LEN_W'(1);
                idx_d = '0;
                if (code_q == sdresp_pkg::CMD_READ_BLOCK) begin
                  mode_d   = sdresp_pkg::MODE_READ;
                  len_d    = sdresp_pkg::LEN_W'(sdresp_pkg::REPLY_DEPTH);
                  sec_ok_d = sec_full < 32'(sdresp_pkg::DISK_SECTORS);
                  sec_d    = sec_full[sdresp_pkg::SECTOR_W-1:0];
                end else if (code_q == sdresp_pkg::CMD_WRITE_BLOCK) begin
                  mode_d   = sdresp_pkg::MODE_WAIT;
                  sec_ok_d = sec_full < 32'(sdresp_pkg::DISK_SECTORS);
                  sec_d    = sec_full[sdresp_pkg::SECTOR_W-1:0];
                end
              end
            endcase
          end
        end
        sdresp_pkg::MODE_READ: begin
          if (idx_inc == sdresp_pkg::IDX_W'(len_q) + 1'b1) begin
            mode_d = sdresp_pkg::MODE_CMD;
            len_d  = '0;
            idx_d  = sdresp_pkg::IDX_W'(1);
          end
        end
        sdresp_pkg::MODE_WAIT: begin
          if (value_i == sdresp_pkg::TOKEN_START) begin
            mode_d = sdresp_pkg::MODE_RECV;
          end
        end
        sdresp_pkg::MODE_RECV: begin
          cnt_d = cnt_q + 1'b1;
          if (sec_ok_q &&
              (cnt_q == sdresp_pkg::CNT_W'(sdresp_pkg::WORDS_PER_SECTOR - 1))) begin
            sect_vld_d[sec_q] = 1'b1;
          end
          if (cnt_q == sdresp_pkg::CNT_W'(sdresp_pkg::WORDS_PER_SECTOR + 1)) begin
            ack_d  = 1'b1;
            len_d  = sdresp_pkg::LEN_W'(1);
            idx_d  = '0;
            cnt_d  = '0;
            mode_d = sdresp_pkg::MODE_CMD;
          end
        end
        default: begin
          mode_d = sdresp_pkg::MODE_CMD;
        end
      endcase
    end
  end

  // Port read: pick a constant reply word or fetch a sector word from the store.
  always_comb begin
    sel_mem_d = 1'b0;
    mem_ok_d  = sec_ok_q && sect_vld_q[sec_q];
    cval_d    = sdresp_pkg::NO_REPLY;
    if ((idx_q != '0) && (sdresp_pkg::IDX_W'(len_q) >= idx_q)) begin
      if (idx_q == sdresp_pkg::IDX_W'(1)) begin
        cval_d = ack_q ? sdresp_pkg::RESP_DATA_OK : sdresp_pkg::RESP_OK;
      end else if (idx_q == sdresp_pkg::IDX_W'(2)) begin
        cval_d = sdresp_pkg::TOKEN_BYTE;
      end else begin
        sel_mem_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= sdresp_pkg::MODE_CMD;
      cnt_q      <= '0;
      idx_q      <= sdresp_pkg::IDX_W'(1);
      len_q      <= '0;
      ack_q      <= 1'b0;
      sec_ok_q   <= 1'b0;
      off_q      <= '0;
      sect_vld_q <= '0;
      pend_q     <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      mode_q     <= mode_d;
      cnt_q      <= cnt_d;
      idx_q      <= idx_d;
      len_q      <= len_d;
      ack_q      <= ack_d;
      sec_ok_q   <= sec_ok_d;
      sect_vld_q <= sect_vld_d;
      pend_q     <= acc_rd;
      out_vld_q  <= pend_q;
      if (cfg_we_i) begin
        off_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sec_q  <= sec_d;
    code_q <= code_d;
    arg_q  <= arg_d;
    if (acc_rd) begin
      sel_mem_q <= sel_mem_d;
      mem_ok_q  <= mem_ok_d;
      cval_q    <= cval_d;
    end
    if (pend_q) begin
      if (sel_mem_q) begin
        out_q <= mem_ok_q ? rdata_q : '0;
      end else begin
        out_q <= {24'd0, cval_q};
      end
    end
  end

  // Sector store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[wr_addr] <= value_i;
    end
    if (acc_rd) begin
      rdata_q <= store_mem[rd_addr];
    end
  end

  assign result_valid_o = out_vld_q;
  assign read_data_o    = out_q;

endmodule

FILE: rtl/sdresp_chk.sv
// Port-level timing checks for the SPI-mode SD card word responder, with bind.
module sdresp_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic operation_i,
  input logic result_valid_o
);

  a_read_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && operation_i |=> busy)
    else $error("read transaction did not raise busy");

  a_read_gives_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && operation_i |=> ##1 result_valid_o)
    else $error("read transaction produced no reply two cycles later");

  a_write_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && !operation_i |=> !busy && !result_valid_o)
    else $error("write transaction raised busy or a reply");

  a_reply_follows_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy) && !busy)
    else $error("reply strobe without a preceding busy cycle");

endmodule

bind spi_sd_card_word_responder sdresp_chk u_sdresp_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .operation_i    (operation_i),
  .result_valid_o (result_valid_o)
);

FILE: dv/spi_sd_card_word_responder_tb.sv
// Self-checking testbench for the SPI-mode SD card word responder.
`timescale 1ns / 100ps

module spi_sd_card_word_responder_tb;
  import sdresp_pkg::*;

  // Port direction of one request transaction.
  localparam logic OP_PORT_WRITE = 1'b0;
  localparam logic OP_PORT_READ  = 1'b1;

  localparam int unsigned POS_CEILING      = 32'h0000_FFFF;
  localparam int unsigned PHASE_ITEMS      = 100;
  localparam int unsigned SATURATION_RUN   = 520;
  localparam int unsigned CFG_QUIET_CYCLES = 4;
  localparam int unsigned TAIL_CYCLES      = 16;
  localparam int unsigned DRAIN_LIMIT      = 1000;
  localparam int unsigned MAX_REPORTS      = 40;
  localparam int unsigned TIMEOUT_NS       = 10_000_000;

  typedef enum logic {
    TXN_PORT,
    TXN_CFG
  } txn_kind_e;

  // One entry of the stimulus list: a port transaction or a sector offset write.
  typedef struct {
    txn_kind_e   kind;
    logic        op;
    logic [31:0] value;
    int unsigned idle_pct;
  } card_txn_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        start       = 1'b0;
  logic        busy;
  logic        operation_i = 1'b0;
  logic [31:0] value_i     = '0;
  logic        result_valid_o;
  logic [31:0] read_data_o;
  logic        cfg_we_i    = 1'b0;
  logic [31:0] cfg_wdata_i = '0;

  spi_sd_card_word_responder u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .operation_i    (operation_i),
    .value_i        (value_i),
    .result_valid_o (result_valid_o),
    .read_data_o    (read_data_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stimulus list filled up front, and the reply words still owed by the card.
  card_txn_t   pending_txns[$];
  logic [31:0] expected_replies[$];

  int unsigned error_count    = 0;
  int unsigned reports_shown  = 0;
  int unsigned port_txns_done = 0;
  int unsigned replies_seen   = 0;
  int unsigned cfg_quiet      = 0;

  // Generator bookkeeping. The generator tracks the offset it has scheduled so
  // that sector numbers can be aimed at the store.
  int unsigned gen_idle_pct   = 0;
  int unsigned gen_items      = 0;
  int unsigned gen_sec_writes = 0;
  int unsigned gen_sec_reads  = 0;
  logic [31:0] gen_offset     = '0;

  // ---------------------------------------------------------------------------
  // Card predictor: its own copy of the card state, advanced once per accepted
  // transaction in the driver.
  // ---------------------------------------------------------------------------
  mode_e       card_mode;
  logic [31:0] cmd_buf   [CMD_WORDS-1];
  logic [31:0] stage_buf [WORDS_PER_SECTOR];
  logic [31:0] reply_buf [REPLY_DEPTH];
  logic [31:0] disk_words[STORE_WORDS];
  logic [31:0] target_sec;
  logic [31:0] offset_reg;
  int unsigned rx_count;
  int unsigned reply_len;
  // Reply position kept as position + 1, so 0 means "before the first word".
  int unsigned reply_pos;

  // Six command words have arrived: build the reply and switch modes.
  function automatic void decode_card_command();
    logic [31:0] code;
    logic [31:0] arg;
    logic [31:0] sector;
    int unsigned base;
    code   = cmd_buf[0];
    // The argument words are ORed as whole words, so stray upper bits leak in.
    arg    = (cmd_buf[1] << 24) | (cmd_buf[2] << 16) | (cmd_buf[3] << 8) | cmd_buf[4];
    sector = arg - offset_reg;
    reply_buf[0] = {24'h0, RESP_OK};
    reply_len    = 1;
    if (code == CMD_READ_BLOCK) begin
      card_mode    = MODE_READ;
      reply_buf[1] = TOKEN_START;
      base         = (sector < DISK_SECTORS) ? sector * WORDS_PER_SECTOR : 0;
      for (int unsigned i = 0; i < WORDS_PER_SECTOR; i++) begin
        reply_buf[2 + i] = (sector < DISK_SECTORS) ? disk_words[base + i] : '0;
      end
      reply_len = REPLY_DEPTH;
    end else if (code == CMD_WRITE_BLOCK) begin
      card_mode  = MODE_WAIT;
      target_sec = sector;
    end
    reply_pos = 0;
  endfunction

  function automatic void card_port_write(logic [31:0] word);
    int unsigned base;
    // Every port write moves the reply position, whatever the mode.
    if (reply_pos < POS_CEILING) reply_pos++;
    case (card_mode)
      MODE_CMD: begin
        // Idle words are only skipped before a command has started.
        if (word[7:0] != IDLE_BYTE || rx_count != 0) begin
          if (rx_count < CMD_WORDS - 1) cmd_buf[rx_count] = word;
          rx_count++;
          if (rx_count >= CMD_WORDS) begin
            decode_card_command();
            rx_count = 0;
          end
        end
      end
      MODE_READ: begin
        // The write that runs past the last reply word ends the read; that
        // word is not taken as part of a new command.
        if (reply_pos == reply_len + 1) begin
          card_mode = MODE_CMD;
          reply_len = 0;
          reply_pos = 1;
        end
      end
      MODE_WAIT: begin
        if (word == TOKEN_START) card_mode = MODE_RECV;
      end
      default: begin
        if (rx_count < WORDS_PER_SECTOR) stage_buf[rx_count] = word;
        rx_count++;
        // Commit on the last data word; writes beyond the disk are dropped.
        if (rx_count == WORDS_PER_SECTOR && target_sec < DISK_SECTORS) begin
          base = target_sec * WORDS_PER_SECTOR;
          for (int unsigned i = 0; i < WORDS_PER_SECTOR; i++) begin
            disk_words[base + i] = stage_buf[i];
          end
        end
        // Two checksum words follow the data, then the data-accepted reply.
        if (rx_count >= WORDS_PER_SECTOR + 2) begin
          reply_buf[0] = {24'h0, RESP_DATA_OK};
          reply_len    = 1;
          reply_pos    = 0;
          rx_count     = 0;
          card_mode    = MODE_CMD;
        end
      end
    endcase
  endfunction

  function automatic logic [31:0] card_port_read();
    if (reply_pos >= 1 && reply_pos - 1 < reply_len) return reply_buf[reply_pos - 1];
    return {24'h0, NO_REPLY};
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus building blocks.
  // ---------------------------------------------------------------------------
  function automatic void push_port(logic op, logic [31:0] word);
    card_txn_t txn;
    txn.kind     = TXN_PORT;
    txn.op       = op;
    txn.value    = word;
    txn.idle_pct = gen_idle_pct;
    pending_txns.push_back(txn);
    gen_items++;
  endfunction

  function automatic void push_cfg(logic [31:0] offset);
    card_txn_t txn;
    txn.kind     = TXN_CFG;
    txn.op       = OP_PORT_WRITE;
    txn.value    = offset;
    txn.idle_pct = 0;
    pending_txns.push_back(txn);
    gen_offset = offset;
  endfunction

  function automatic logic [31:0] idle_word();
    logic [31:0] word;
    word      = $urandom();
    word[7:0] = IDLE_BYTE;
    return word;
  endfunction

  // Data words lean toward the values the card treats specially.
  function automatic logic [31:0] data_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return TOKEN_START;
      3:       return idle_word();
      default: return $urandom();
    endcase
  endfunction

  // Sector numbers cluster on a few low sectors so read-backs hit written data.
  function automatic logic [31:0] pick_sector();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 60) return $urandom_range(3);
    if (roll < 70) return DISK_SECTORS - 1;
    if (roll < 80) return DISK_SECTORS + $urandom_range(63);
    if (roll < 90) return $urandom();
    return $urandom_range(DISK_SECTORS - 1);
  endfunction

  // Optional leading idle words, code, four argument words and a checksum word.
  // Scrambled arguments carry full 32-bit words that overlap when ORed.
  function automatic void push_command(logic [31:0] code, logic [31:0] arg, bit scramble);
    for (int unsigned k = $urandom_range(2); k > 0; k--) push_port(OP_PORT_WRITE, idle_word());
    push_port(OP_PORT_WRITE, code);
    if (scramble) begin
      for (int unsigned k = 0; k < 4; k++) push_port(OP_PORT_WRITE, $urandom());
    end else begin
      push_port(OP_PORT_WRITE, {24'h0, arg[31:24]});
      push_port(OP_PORT_WRITE, {24'h0, arg[23:16]});
      push_port(OP_PORT_WRITE, {24'h0, arg[15:8]});
      push_port(OP_PORT_WRITE, {24'h0, arg[7:0]});
    end
    push_port(OP_PORT_WRITE, $urandom());
  endfunction

  // Read command, then walk the whole reply with reads scattered between the
  // advancing writes; the last write drops the card back into command mode.
  function automatic void issue_sector_read(logic [31:0] arg, bit scramble);
    push_command(CMD_READ_BLOCK, arg, scramble);
    push_port(OP_PORT_READ, $urandom());
    for (int unsigned k = 0; k < REPLY_DEPTH + 1; k++) begin
      push_port(OP_PORT_WRITE, data_word());
      if ($urandom_range(9) < 3) push_port(OP_PORT_READ, $urandom());
    end
    push_port(OP_PORT_READ, $urandom());
    gen_sec_reads++;
  endfunction

  // Write command, a few non-token words, the start token, a sector of data,
  // two checksum words, and a look at the data-accepted reply.
  function automatic void issue_sector_write(logic [31:0] arg, bit scramble);
    logic [31:0] junk;
    push_command(CMD_WRITE_BLOCK, arg, scramble);
    push_port(OP_PORT_READ, $urandom());
    for (int unsigned k = $urandom_range(3); k > 0; k--) begin
      junk = $urandom();
      // A word whose low byte is the token but whose upper bits are not zero.
      if ($urandom_range(1)) junk = {junk[31:8] | 24'h1, TOKEN_BYTE};
      if (junk == TOKEN_START) junk[0] = ~junk[0];
      push_port(OP_PORT_WRITE, junk);
      push_port(OP_PORT_READ, $urandom());
    end
    push_port(OP_PORT_WRITE, TOKEN_START);
    for (int unsigned k = 0; k < WORDS_PER_SECTOR + 2; k++) begin
      push_port(OP_PORT_WRITE, data_word());
      if ($urandom_range(19) == 0) push_port(OP_PORT_READ, $urandom());
    end
    push_port(OP_PORT_READ, $urandom());
    push_port(OP_PORT_WRITE, idle_word());
    push_port(OP_PORT_READ, $urandom());
    gen_sec_writes++;
  endfunction

  // Any other command just answers a single zero word.
  function automatic void issue_plain_command();
    logic [31:0] code;
    code = $urandom();
    case ($urandom_range(3))
      0:       code = {code[31:8] | 24'h1, CMD_READ_BLOCK[7:0]};
      1:       code = {code[31:8] | 24'h1, CMD_WRITE_BLOCK[7:0]};
      2:       code = $urandom_range(63);
      default: ;
    endcase
    if (code[7:0] == IDLE_BYTE || code == CMD_READ_BLOCK || code == CMD_WRITE_BLOCK) begin
      code[0] = ~code[0];
    end
    push_command(code, $urandom(), $urandom_range(1) == 1);
    push_port(OP_PORT_READ, $urandom());
    push_port(OP_PORT_WRITE, idle_word());
    push_port(OP_PORT_READ, $urandom());
    if ($urandom_range(1)) begin
      push_port(OP_PORT_WRITE, idle_word());
      push_port(OP_PORT_READ, $urandom());
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: launches transactions from the list, with random gaps, and feeds
  // every accepted transaction to the predictor. Offset writes wait until the
  // card is idle and every owed reply has come back.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : drive_proc
    logic      fire;
    logic      drive_start;
    logic      drive_we;
    card_txn_t head;
    fire        = start && !busy;
    drive_start = start && !fire;
    drive_we    = 1'b0;
    if (fire) begin
      port_txns_done++;
      if (operation_i == OP_PORT_READ) expected_replies.push_back(card_port_read());
      else card_port_write(value_i);
    end
    if (rst_ni && !drive_start && pending_txns.size() != 0) begin
      head = pending_txns[0];
      if (head.kind == TXN_CFG) begin
        if (!fire && !busy && expected_replies.size() == 0) cfg_quiet++;
        else cfg_quiet = 0;
        if (cfg_quiet >= CFG_QUIET_CYCLES) begin
          drive_we    = 1'b1;
          cfg_wdata_i <= head.value;
          offset_reg  = head.value;
          cfg_quiet   = 0;
          void'(pending_txns.pop_front());
        end
      end else if ($urandom_range(99) >= head.idle_pct) begin
        drive_start = 1'b1;
        operation_i <= head.op;
        value_i     <= head.value;
        void'(pending_txns.pop_front());
      end
    end
    start    <= drive_start;
    cfg_we_i <= drive_we;
  end

  // ---------------------------------------------------------------------------
  // Monitor: every reply strobe is matched against the oldest owed reply.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_proc
    logic [31:0] want;
    if (rst_ni && result_valid_o) begin
      if (expected_replies.size() == 0) begin
        error_count++;
        if (reports_shown < MAX_REPORTS) begin
          reports_shown++;
          $display("%0t: reply with none owed: expected none, actual %h", $time, read_data_o);
        end
      end else begin
        want = expected_replies.pop_front();
        replies_seen++;
        if (read_data_o !== want) begin
          error_count++;
          if (reports_shown < MAX_REPORTS) begin
            reports_shown++;
            $display("%0t: read_data mismatch: expected %h, actual %h", $time, want,
                     read_data_o);
          end
        end
      end
    end
  end

  initial begin : stimulus_proc
    int unsigned phase_end;
    int unsigned roll;
    int unsigned drain;
    int unsigned idle_by_phase[3];
    logic [31:0] offset_by_phase[3];
    logic [31:0] opener_sector[3];

    // Card state after reset: empty disk, command mode, nothing to reply.
    card_mode  = MODE_CMD;
    rx_count   = 0;
    reply_len  = 0;
    reply_pos  = 1;
    target_sec = '0;
    offset_reg = '0;
    for (int unsigned i = 0; i < STORE_WORDS; i++) disk_words[i] = '0;

    idle_by_phase[0]   = 12;
    idle_by_phase[1]   = 73;
    idle_by_phase[2]   = 0;
    offset_by_phase[0] = 32'hFFFF_FFFF;
    offset_by_phase[1] = $urandom();
    offset_by_phase[2] = 32'h0;
    opener_sector[0]   = 0;
    opener_sector[1]   = DISK_SECTORS - 1;
    opener_sector[2]   = 0;

    // Directed opening at the reset offset: nothing pending after reset, idle
    // words skipped, a code that only matches in its low byte, argument words
    // with upper bits set, and the single-word reply walked past its end.
    gen_idle_pct = idle_by_phase[0];
    push_port(OP_PORT_READ, 32'hFFFF_FFFF);
    push_port(OP_PORT_WRITE, 32'hFFFF_FFFF);
    push_port(OP_PORT_WRITE, 32'h0000_01FF);
    push_port(OP_PORT_WRITE, {24'h1, CMD_READ_BLOCK[7:0]});
    push_port(OP_PORT_WRITE, 32'hFFFF_FFFF);
    push_port(OP_PORT_WRITE, 32'h0000_0000);
    push_port(OP_PORT_WRITE, 32'h1234_5678);
    push_port(OP_PORT_WRITE, 32'h0000_00FF);
    push_port(OP_PORT_WRITE, 32'h0000_0000);
    push_port(OP_PORT_READ, 32'h0000_0000);
    push_port(OP_PORT_WRITE, 32'h0000_00FF);
    push_port(OP_PORT_READ, 32'h0000_0000);
    push_port(OP_PORT_WRITE, 32'h0000_00FF);
    push_port(OP_PORT_READ, 32'h0000_0000);

    // Three phases, each with its own offset and sender gap rate. Each opens
    // with a write and read-back of one sector, then mixes sector transfers,
    // plain commands, and reads and idle words as noise.
    for (int unsigned phase = 0; phase < 3; phase++) begin
      gen_idle_pct = idle_by_phase[phase];
      push_cfg(offset_by_phase[phase]);
      issue_sector_write(gen_offset + opener_sector[phase], 1'b0);
      issue_sector_read(gen_offset + opener_sector[phase], 1'b0);
      phase_end = gen_items + PHASE_ITEMS;
      while (gen_items < phase_end) begin
        roll = $urandom_range(99);
        if (roll < 30) begin
          issue_sector_write(gen_offset + pick_sector(), $urandom_range(9) == 0);
        end else if (roll < 50) begin
          issue_sector_read(gen_offset + pick_sector(), $urandom_range(9) == 0);
        end else if (roll < 80) begin
          issue_plain_command();
        end else begin
          for (int unsigned k = $urandom_range(1, 6); k > 0; k--) begin
            if ($urandom_range(1)) push_port(OP_PORT_READ, $urandom());
            else push_port(OP_PORT_WRITE, idle_word());
          end
        end
      end
    end

    // A reply followed by a long run of idle words: the reply position must
    // saturate rather than wrap back onto the stale reply.
    push_command($urandom_range(63), $urandom(), 1'b0);
    for (int unsigned k = 0; k < SATURATION_RUN; k++) begin
      push_port(OP_PORT_WRITE, idle_word());
      if (k % 97 == 0) push_port(OP_PORT_READ, $urandom());
    end
    push_port(OP_PORT_READ, $urandom());

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (port_txns_done < gen_items) @(posedge clk_i);
    drain = 0;
    while (expected_replies.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk_i);
      drain++;
    end
    if (expected_replies.size() != 0) begin
      error_count += expected_replies.size();
      $display("%0t: %0d replies never arrived: expected %h first, actual none", $time,
               expected_replies.size(), expected_replies[0]);
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d port transactions with %0d replies checked, %0d sector writes",
             port_txns_done, replies_seen, gen_sec_writes);
    $display("and %0d sector reads under three offsets, and a reply position saturation run.",
             gen_sec_reads);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake or a reply that never comes.
  initial begin : watchdog_proc
    #TIMEOUT_NS;
    $display("Verification failed");
    $finish;
  end

endmodule

FILE: sim.f
rtl/sdresp_pkg.sv
rtl/spi_sd_card_word_responder.sv
rtl/sdresp_chk.sv
dv/spi_sd_card_word_responder_tb.sv
